FILE: sv/dexs_pkg.sv
// ----------------------------------------------------------------------------
// dexs_pkg - shared constants for the double exponential smoother
// Default widths of the data path and the item opcodes.
// ----------------------------------------------------------------------------
package dexs_pkg;

  // signed Q16.16 data and Q0.16 gain by default
  localparam int DATA_WIDTH     = 32;
  localparam int GAIN_FRAC_BITS = 16;

  // opcode carried on the input tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

endpackage

FILE: sv/double_exponential_smoother.sv
// ----------------------------------------------------------------------------
// double_exponential_smoother - one-step predictor from two cascaded averages
// Brown double exponential smoothing in fixed point with a saturated output.
// ----------------------------------------------------------------------------
// Takes signed Q16.16 items on the input stream. A sample item (tuser low)
// updates S1 = a*x + (1-a)*S1 and S2 = a*S1 + (1-a)*S2, both rounded to
// nearest, and returns one item with the prediction 2*S1 - S2 + k*(S1 - S2),
// k = a/(1-a), the trend term rounded to nearest with ties away from zero,
// clipped to the data range with the clip flag on tuser. The first sample
// after reset seeds both averages, so its prediction equals the sample. A
// load item (tuser high) sets both averages and returns nothing. The gain a
// is cfg_wdata / 2^GAIN_FRAC_BITS; write it only while the block is idle.
// Items are handled one at a time: a sample occupies the block while the
// bit-serial multiplier runs three times (two blends, one trend product)
// and the restoring divider forms the trend term one quotient bit per
// cycle. A load item does not make the block busy. The finished result
// sits in an output register, so a new item is taken while it waits.
// ----------------------------------------------------------------------------
module double_exponential_smoother #(
  parameter int DATA_WIDTH     = dexs_pkg::DATA_WIDTH,
  parameter int GAIN_FRAC_BITS = dexs_pkg::GAIN_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // gain register, unsigned Q0.GAIN_FRAC_BITS
  input  logic                               cfg_wen,
  input  logic [GAIN_FRAC_BITS-1:0]          cfg_wdata,
  // input items
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]    s_tdata,   // sample_value
  input  logic [0:0]                         s_tuser,   // opcode
  // result items
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]    m_tdata,   // predicted_value
  output logic [0:0]                         m_tuser    // saturated
);

  localparam int DW  = DATA_WIDTH;
  localparam int GF  = GAIN_FRAC_BITS;
  localparam int TDW = ((DW + 7) / 8) * 8;
  localparam int AW  = DW + 1;        // difference of two averages
  localparam int NW  = DW + GF;       // trend dividend magnitude
  localparam int PW  = DW + GF + 2;   // full multiplier product
  localparam int SW  = DW + GF + 2;   // prediction before clipping

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL1  = 3'd1;
  localparam logic [2:0] ST_PREP2 = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_PREP3 = 3'd4;
  localparam logic [2:0] ST_MUL3  = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  // clip limits at the width of the unclipped sum
  localparam logic signed [SW-1:0] PRED_MAX = {{(SW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [SW-1:0] PRED_MIN = {{(SW - DW + 1){1'b1}}, {(DW - 1){1'b0}}};

  logic [2:0]           state;
  logic [GF-1:0]        alpha;
  logic                 avg_valid;
  logic signed [DW-1:0] s1;
  logic signed [DW-1:0] s2;
  logic signed [DW+1:0] base;      // 2*S1 - S2
  logic                 neg;       // sign of the trend product
  logic [GF:0]          dv;        // 1 - a, never zero
  logic [GF-1:0]        hd;        // half the divisor, for rounding
  logic [GF-1:0]        hd1;       // half the divisor plus one (negative case)
  logic                 out_valid;
  logic [DW-1:0]        out_data;
  logic                 out_sat;

  logic                 accept;
  logic signed [DW-1:0] x;
  logic signed [DW-1:0] s1_eff;
  logic [GF:0]          dv_c;

  logic                 mul_start;
  logic signed [AW-1:0] mul_mcand;
  logic                 mul_done;
  logic signed [AW:0]   prod_hi;
  logic [GF-1:0]        prod_lo;
  logic [PW-1:0]        prod;
  logic [NW-1:0]        p_low;
  logic                 neg_p;

  logic                 div_start;
  logic [NW-1:0]        div_num;
  logic                 div_done;
  logic [NW-1:0]        quot;

  logic [DW-1:0]        s_base;
  logic [DW-1:0]        blended;
  logic signed [SW-1:0] base_ext;
  logic signed [SW-1:0] quot_ext;
  logic signed [SW-1:0] sum;
  logic [DW-1:0]        pred;
  logic                 clip;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign x        = $signed(s_tdata[DW-1:0]);

  // an empty average acts as if it already held the sample
  assign s1_eff = avg_valid ? s1 : x;

  // 1 - a in Q0.GF
  assign dv_c = {1'b1, {GF{1'b0}}} - {1'b0, alpha};

  // multiplier feeds: x - S1 for the first blend, S1 - S2 for the others
  always_comb begin
    case (state)
      ST_IDLE:  mul_mcand = {x[DW-1], x} - {s1_eff[DW-1], s1_eff};
      ST_PREP2,
      ST_PREP3: mul_mcand = {s1[DW-1], s1} - {s2[DW-1], s2};
      default:  mul_mcand = '0;
    endcase
  end

  assign mul_start = (accept && (s_tuser[0] == dexs_pkg::OP_SAMPLE)) ||
                     (state == ST_PREP2) || (state == ST_PREP3);

  dexs_mul #(
    .AW (AW),
    .BW (GF)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (alpha),
    .done    (mul_done),
    .prod_hi (prod_hi),
    .prod_lo (prod_lo)
  );

  // blend: S + floor((a*(u - S) + half) / 2^GF), the half folded in as the
  // top fraction bit of the product
  assign s_base  = (state == ST_MUL1) ? s1 : s2;
  assign blended = s_base + prod_hi[DW-1:0] + {{(DW - 1){1'b0}}, prod_lo[GF-1]};

  // trend dividend |a*(S1 - S2)| + (1 - a)/2, negation as invert plus one
  assign prod    = {prod_hi, prod_lo};
  assign neg_p   = prod[PW-1];
  assign p_low   = prod[NW-1:0];
  assign div_num = (neg_p ? ~p_low : p_low) + (neg_p ? NW'(hd1) : NW'(hd));

  assign div_start = (state == ST_MUL3) && mul_done;

  dexs_div #(
    .NW  (NW),
    .DVW (GF + 1)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .numer   (div_num),
    .divisor (dv),
    .done    (div_done),
    .quot    (quot)
  );

  // prediction and clipping
  assign base_ext = SW'(base);
  assign quot_ext = $signed({2'b00, quot});
  assign sum      = neg ? (base_ext - quot_ext) : (base_ext + quot_ext);

  always_comb begin
    clip = 1'b0;
    pred = sum[DW-1:0];
    if (sum > PRED_MAX) begin
      clip = 1'b1;
      pred = PRED_MAX[DW-1:0];
    end else if (sum < PRED_MIN) begin
      clip = 1'b1;
      pred = PRED_MIN[DW-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      alpha     <= GF'(1) << (GF - 1);
      avg_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        alpha <= cfg_wdata;
      end
      // the finishing state refills the output register itself
      if (out_valid && m_tready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            avg_valid <= 1'b1;
            if (s_tuser[0] == dexs_pkg::OP_SAMPLE) begin
              state <= ST_MUL1;
            end
          end
        end
        ST_MUL1: begin
          if (mul_done) begin
            state <= ST_PREP2;
          end
        end
        ST_PREP2: state <= ST_MUL2;
        ST_MUL2: begin
          if (mul_done) begin
            state <= ST_PREP3;
          end
        end
        ST_PREP3: state <= ST_MUL3;
        ST_MUL3: begin
          if (mul_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // wait for the output register to free up
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // data path registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dv  <= dv_c;
      hd  <= dv_c[GF:1];
      hd1 <= dv_c[GF:1] + 1'b1;
      // a load item, or the first sample, seeds both averages
      if ((s_tuser[0] == dexs_pkg::OP_LOAD) || !avg_valid) begin
        s1 <= x;
        s2 <= x;
      end
    end
    if ((state == ST_MUL1) && mul_done) begin
      s1 <= $signed(blended);
    end
    if ((state == ST_MUL2) && mul_done) begin
      s2 <= $signed(blended);
    end
    if (state == ST_PREP3) begin
      base <= {s1[DW-1], s1, 1'b0} - {{2{s2[DW-1]}}, s2};
    end
    if (div_start) begin
      neg <= neg_p;
    end
    if ((state == ST_FIN) && (!out_valid || m_tready)) begin
      out_data <= pred;
      out_sat  <= clip;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = TDW'(out_data);
  assign m_tuser[0] = out_sat;

endmodule

FILE: sv/dexs_mul.sv
// ----------------------------------------------------------------------------
// dexs_mul - serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle,
// lsb first; the product shifts out through prod_lo.
// ----------------------------------------------------------------------------
module dexs_mul #(
  parameter int AW = 33,
  parameter int BW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] mcand,
  input  logic        [BW-1:0] mplier,
  output logic                 done,
  output logic signed [AW:0]   prod_hi,
  output logic        [BW-1:0] prod_lo
);

  localparam int CW = $clog2(BW + 1);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [BW-1:0]        mp;
  logic signed [AW-1:0] mc;
  logic signed [AW:0]   hi;
  logic [BW-1:0]        lo;
  logic [AW:0]          sum;

  // partial sum of the current bit
  assign sum = hi + (mp[0] ? {mc[AW-1], mc} : {(AW + 1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc <= mcand;
      mp <= mplier;
      hi <= '0;
      lo <= '0;
    end else if (busy) begin
      hi <= $signed({sum[AW], sum[AW:1]});
      lo <= {sum[0], lo[BW-1:1]};
      mp <= mp >> 1;
    end
  end

  assign prod_hi = hi;
  assign prod_lo = lo;

endmodule

FILE: sv/dexs_div.sv
// ----------------------------------------------------------------------------
// dexs_div - serial restoring divider
// Unsigned quotient, one bit per cycle, msb first; the dividend shifts out
// of the top of the quotient register as the quotient shifts in.
// ----------------------------------------------------------------------------
module dexs_div #(
  parameter int NW  = 48,
  parameter int DVW = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  numer,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [NW-1:0]  quot
);

  localparam int CW = $clog2(NW + 1);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [NW-1:0]  qr;
  logic [DVW-1:0] rem;
  logic [DVW-1:0] dv;
  logic [DVW:0]   trial;

  // remainder stays below the divisor, so its top bit is free
  assign trial = {rem, qr[NW-1]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= numer;
      rem <= '0;
      dv  <= divisor;
    end else if (busy) begin
      if (!trial[DVW]) begin
        rem <= trial[DVW-1:0];
        qr  <= {qr[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[DVW-2:0], qr[NW-1]};
        qr  <= {qr[NW-2:0], 1'b0};
      end
    end
  end

  assign quot = qr;

endmodule

FILE: sv/dexs_checker.sv
// ----------------------------------------------------------------------------
// dexs_checker - port-level checks for the double exponential smoother
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module dexs_checker #(
  parameter int DATA_WIDTH = dexs_pkg::DATA_WIDTH
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [0:0]                      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic [0:0]                      m_tuser
);

  localparam int DW = DATA_WIDTH;

  localparam logic [DW-1:0] DATA_MAX = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0] DATA_MIN = {1'b1, {(DW - 1){1'b0}}};

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item present after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result item changed");

  // a sample item keeps the block busy for the next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == dexs_pkg::OP_SAMPLE) |=> !s_tready)
    else $error("ready right after a sample item");

  // a load item finishes at once
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == dexs_pkg::OP_LOAD) |=> s_tready)
    else $error("not ready after a load item");

  // a clipped prediction sits on a range limit
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      (m_tdata[DW-1:0] == DATA_MAX) || (m_tdata[DW-1:0] == DATA_MIN))
    else $error("clip flag without a range limit");

endmodule

bind double_exponential_smoother dexs_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_dexs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
